### rtl/vpd_pkg.sv
// Shared types and constants for the VP9 payload descriptor parser.
package vpd_pkg;

  // Byte beat on the input channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } vpd_in_t;

  // Result beat, one per payload
  typedef struct packed {
    logic        descriptor_valid;
    logic        start_of_frame;
    logic        end_of_frame;
    logic [10:0] payload_offset;
  } vpd_out_t;

  // Parse phase: the descriptor field the next byte belongs to
  typedef enum logic [10:0] {
    PH_DESC  = 11'b000_0000_0001,
    PH_PID1  = 11'b000_0000_0010,
    PH_PID2  = 11'b000_0000_0100,
    PH_LAYER = 11'b000_0000_1000,
    PH_TL0   = 11'b000_0001_0000,
    PH_PDIFF = 11'b000_0010_0000,
    PH_SS    = 11'b000_0100_0000,
    PH_RES   = 11'b000_1000_0000,
    PH_NG    = 11'b001_0000_0000,
    PH_GHDR  = 11'b010_0000_0000,
    PH_GREF  = 11'b100_0000_0000
  } vpd_phase_t;

  // Bit positions in the stored flag register (I,P,L,F,B,E,V in 6..0)
  localparam int unsigned FL_I = 6;
  localparam int unsigned FL_G = 6;  // reuses I once the SS byte is read
  localparam int unsigned FL_P = 5;
  localparam int unsigned FL_L = 4;
  localparam int unsigned FL_F = 3;
  localparam int unsigned FL_B = 2;
  localparam int unsigned FL_E = 1;
  localparam int unsigned FL_V = 0;

endpackage

### rtl/vpd_step.sv
// Descriptor walk: parse state registers and the per-byte update logic.
module vpd_step
  import vpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     beat_en,
  input  vpd_in_t  beat,
  output vpd_out_t res
);

  // Entry points for the optional-section search
  typedef enum logic [1:0] {
    ENT_PID1  = 2'd0,
    ENT_LAYER = 2'd1,
    ENT_PDIFF = 2'd2,
    ENT_SS    = 2'd3
  } vpd_entry_t;

  typedef struct packed {
    vpd_phase_t phase;
    logic       done;
  } vpd_next_t;

  vpd_phase_t  phase_r, phase_nxt;
  logic [6:0]  flags_r, flags_nxt;
  logic [10:0] count_r, count_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic [7:0]  groups_r, groups_nxt;
  logic [1:0]  diff_r, diff_nxt;
  logic        failed_r, failed_nxt;
  logic        complete_r, complete_nxt;
  logic        ok;

  // First present optional section at or after the entry point
  function automatic vpd_next_t enter_from(input vpd_entry_t from,
                                           input logic [6:0] f,
                                           input vpd_phase_t cur);
    vpd_next_t e;
    e.phase = cur;
    e.done  = 1'b0;
    if (from == ENT_PID1 && f[FL_I]) begin
      e.phase = PH_PID1;
    end else if ((from == ENT_PID1 || from == ENT_LAYER) && f[FL_L]) begin
      e.phase = PH_LAYER;
    end else if (from != ENT_SS && f[FL_F] && f[FL_P]) begin
      e.phase = PH_PDIFF;
    end else if (f[FL_V]) begin
      e.phase = PH_SS;
    end else begin
      e.done = 1'b1;
    end
    return e;
  endfunction

  // Per-byte state update and result
  always_comb begin
    vpd_next_t  e;
    logic [6:0] fl;
    logic [7:0] b;
    b            = beat.data_byte;
    fl           = flags_r;
    e            = '{phase: phase_r, done: 1'b0};
    phase_nxt    = phase_r;
    flags_nxt    = flags_r;
    count_nxt    = count_r;
    skip_nxt     = skip_r;
    groups_nxt   = groups_r;
    diff_nxt     = diff_r;
    failed_nxt   = failed_r;
    complete_nxt = complete_r;

    if (beat_en && !failed_r && !complete_r) begin
      count_nxt = count_r + 11'd1;
      case (phase_r)
        PH_DESC: begin
          fl        = b[7:1];
          flags_nxt = fl;
          e         = enter_from(ENT_PID1, fl, phase_r);
        end
        PH_PID1: begin
          if (b[7]) begin
            phase_nxt = PH_PID2;
          end else begin
            e = enter_from(ENT_LAYER, flags_r, phase_r);
          end
        end
        PH_PID2: begin
          e = enter_from(ENT_LAYER, flags_r, phase_r);
        end
        PH_LAYER: begin
          if (!flags_r[FL_F]) begin
            phase_nxt = PH_TL0;
          end else begin
            e = enter_from(ENT_PDIFF, flags_r, phase_r);
          end
        end
        PH_TL0: begin
          e = enter_from(ENT_PDIFF, flags_r, phase_r);
        end
        PH_PDIFF: begin
          // zero P_DIFF, or a fourth one announced, is illegal
          if (b[7:1] == 7'd0 || (diff_r == 2'd2 && b[0])) begin
            failed_nxt = 1'b1;
          end else if (b[0]) begin
            diff_nxt = diff_r + 2'd1;
          end else begin
            e = enter_from(ENT_SS, flags_r, phase_r);
          end
        end
        PH_SS: begin
          flags_nxt[FL_G] = b[3];
          if (b[4]) begin
            skip_nxt  = 6'(({3'b000, b[7:5]} + 6'd1) << 2);
            phase_nxt = PH_RES;
          end else if (b[3]) begin
            phase_nxt = PH_NG;
          end else begin
            complete_nxt = 1'b1;
          end
        end
        PH_RES: begin
          skip_nxt = skip_r - 6'd1;
          if (skip_nxt == 6'd0) begin
            if (flags_r[FL_G]) begin
              phase_nxt = PH_NG;
            end else begin
              complete_nxt = 1'b1;
            end
          end
        end
        PH_NG: begin
          groups_nxt = b;
          if (b == 8'd0) begin
            complete_nxt = 1'b1;
          end else begin
            phase_nxt = PH_GHDR;
          end
        end
        PH_GHDR: begin
          groups_nxt = groups_r - 8'd1;
          skip_nxt   = {4'b0000, b[3:2]};
          if (b[3:2] != 2'd0) begin
            phase_nxt = PH_GREF;
          end else if (groups_nxt == 8'd0) begin
            complete_nxt = 1'b1;
          end else begin
            phase_nxt = PH_GHDR;
          end
        end
        PH_GREF: begin
          skip_nxt = skip_r - 6'd1;
          if (skip_nxt == 6'd0) begin
            if (groups_r == 8'd0) begin
              complete_nxt = 1'b1;
            end else begin
              phase_nxt = PH_GHDR;
            end
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase

      // apply an optional-section search result
      if (phase_r == PH_DESC || phase_r == PH_PID1 || phase_r == PH_PID2 ||
          phase_r == PH_LAYER || phase_r == PH_TL0 || phase_r == PH_PDIFF) begin
        if (e.done) begin
          complete_nxt = 1'b1;
        end else if (e.phase != phase_r) begin
          phase_nxt = e.phase;
          if (e.phase == PH_PDIFF) begin
            diff_nxt = 2'd0;
          end
        end
      end
    end

    // result from the updated state
    ok                   = complete_nxt && !failed_nxt;
    res.descriptor_valid = ok;
    res.start_of_frame   = ok && flags_nxt[FL_B];
    res.end_of_frame     = ok && flags_nxt[FL_E];
    res.payload_offset   = ok ? count_nxt : 11'd0;

    // final byte returns the walk to its start
    if (beat_en && beat.last_byte) begin
      phase_nxt    = PH_DESC;
      flags_nxt    = '0;
      count_nxt    = '0;
      skip_nxt     = '0;
      groups_nxt   = '0;
      diff_nxt     = '0;
      failed_nxt   = 1'b0;
      complete_nxt = 1'b0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DESC;
      flags_r    <= '0;
      count_r    <= '0;
      skip_r     <= '0;
      groups_r   <= '0;
      diff_r     <= '0;
      failed_r   <= 1'b0;
      complete_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      flags_r    <= flags_nxt;
      count_r    <= count_nxt;
      skip_r     <= skip_nxt;
      groups_r   <= groups_nxt;
      diff_r     <= diff_nxt;
      failed_r   <= failed_nxt;
      complete_r <= complete_nxt;
    end
  end

endmodule

### rtl/vpd_out_reg.sv
// Result register holding one beat for the output channel.
module vpd_out_reg
  import vpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  vpd_out_t load_data,
  input  logic     out_ready,
  output logic     out_valid,
  output vpd_out_t out_data
);

  logic     valid_r, valid_nxt;
  vpd_out_t data_r, data_nxt;

  // Load on a new result, drop when taken
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/vp9_payload_descriptor_parser_core.sv
// Top level of the VP9 RTP payload descriptor parser.
//
//   channel | ports                        | beat
//   --------+------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data  | one payload byte + last flag
//   output  | out_valid, out_ready, out_data | one result per payload
//
// One byte per cycle while not stalled: a byte lands in the input register, then
// the walk logic updates the parse state and, on the final byte, loads the
// result register. A final byte thus passes the input register and then the
// result register before its result is offered on the output channel.
// Input stalls only when a final byte waits on a result not yet taken.
// Synchronous active-low reset returns the walk to the mandatory byte.
module vp9_payload_descriptor_parser_core
  import vpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vpd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output vpd_out_t out_data
);

  logic     s1_valid_r, s1_valid_nxt;
  vpd_in_t  s1_data_r;
  logic     s1_adv;
  vpd_out_t step_res;

  // Stage advances unless a final byte meets a full result register that is not being taken
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_byte || !out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  vpd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat_en (s1_adv),
    .beat    (s1_data_r),
    .res     (step_res)
  );

  vpd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && s1_data_r.last_byte),
    .load_data (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An invalid descriptor reports no flags and no offset
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.descriptor_valid |->
      out_data.payload_offset == 11'd0 && !out_data.start_of_frame &&
      !out_data.end_of_frame)
    else $error("invalid result carries nonzero fields");

  // A valid descriptor has consumed at least the mandatory byte
  a_valid_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.descriptor_valid |-> out_data.payload_offset != 11'd0)
    else $error("valid result with zero offset");

  // Input only stalls behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && s1_valid_r && s1_data_r.last_byte)
    else $error("input stalled without a pending result");

  // A new result follows a final byte leaving the input register
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_adv && s1_data_r.last_byte))
    else $error("result appeared without a final byte");

endmodule
